// File: hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Operation and status codes, default depth and the per-beat control
// record passed from the pointer logic to the result stage.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int WORD_W      = 64;
  localparam int OP_W        = 3;
  localparam int CNT_OUT_W   = 5;
  localparam int DEPTH_DEF   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Everything the result stage needs besides the storage read data.
  typedef struct packed {
    logic [WORD_W-1:0]    push_word;
    logic                 byp_first;
    logic                 byp_last;
    logic                 rev;
    logic                 empty;
    logic [CNT_OUT_W-1:0] entry_count;
    status_t              status;
  } meta_t;

endpackage

// File: hdl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: ring pointers and operation decode
// Holds head slot, word count and direction flag, decides each beat's
// effect, drives the storage write and the reads of both physical ends.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [OP_W-1:0]   op,
  input  logic [WORD_W-1:0] value,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [AW-1:0]     rd_first,
  output logic [AW-1:0]     rd_last,
  output meta_t             meta
);

  localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          rev;
  logic          rev_next;
  op_t           op_c;
  status_t       status;
  logic [CW-1:0] last_off;
  logic [XW-1:0] count_x;

  // Slot a given distance past base, wrapped around the ring.
  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_prev(logic [AW-1:0] base);
    logic [AW-1:0] r;
    if (base == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = base - AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    op_c       = op_t'(op);
    head_next  = head;
    count_next = count;
    rev_next   = rev;
    status     = ST_OK;
    ram_we     = 1'b0;
    ram_waddr  = head;
    case (op_c)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (count >= CW'(DEPTH)) begin
          status = ST_OVERFLOW;
        end else begin
          ram_we     = 1'b1;
          count_next = count + CW'(1);
          if ((op_c == OP_PUSH_BACK) != rev) begin
            ram_waddr = slot_add(head, count);
          end else begin
            head_next = slot_prev(head);
            ram_waddr = head_next;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (count == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          count_next = count - CW'(1);
          if ((op_c == OP_POP_FRONT) != rev) begin
            head_next = slot_add(head, CW'(1));
          end
        end
      end
      OP_REVERSE: begin
        if (count == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          rev_next = ~rev;
        end
      end
      default: begin
      end
    endcase

    // Physical ends after the operation; a write to either end this beat
    // is not yet visible to the read, so it is forwarded.
    last_off = (count_next == '0) ? '0 : count_next - CW'(1);
    rd_first = head_next;
    rd_last  = slot_add(head_next, last_off);
    count_x  = XW'(count_next);

    meta.push_word   = value;
    meta.byp_first   = ram_we && (ram_waddr == rd_first);
    meta.byp_last    = ram_we && (ram_waddr == rd_last);
    meta.rev         = rev_next;
    meta.empty       = (count_next == '0);
    meta.entry_count = count_x[CNT_OUT_W-1:0];
    meta.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("deq_ctrl: word count above depth");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && (status != ST_OK) |=>
      (count == $past(count)) && (head == $past(head)) && (rev == $past(rev)))
    else $error("deq_ctrl: rejected operation changed the queue");

  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (count < CW'(DEPTH)) && (status == ST_OK))
    else $error("deq_ctrl: storage write on a full queue");
`endif

endmodule

// File: hdl/deq_out.sv
// ----------------------------------------------------------------------------
// deq_out: read stage and result register
// Pairs the storage read data with its beat, forwards a fresh push,
// orders the ends by direction and holds the result until it is taken.
// ----------------------------------------------------------------------------
module deq_out import deq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  meta_t                meta,
  input  logic [WORD_W-1:0]    rd_first,
  input  logic [WORD_W-1:0]    rd_last,
  output logic                 take,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [WORD_W-1:0]    front_value,
  output logic [WORD_W-1:0]    back_value,
  output logic [CNT_OUT_W-1:0] entry_count,
  output logic                 is_empty,
  output logic [1:0]           status
);

  logic              s1_valid;
  meta_t             s1_meta;
  logic              s1_adv;
  logic [WORD_W-1:0] first_w;
  logic [WORD_W-1:0] last_w;

  assign s1_adv = s1_valid && (!result_valid || result_ready);
  assign take   = !s1_valid || !result_valid || result_ready;

  always_comb begin
    first_w = s1_meta.byp_first ? s1_meta.push_word : rd_first;
    last_w  = s1_meta.byp_last ? s1_meta.push_word : rd_last;
    if (s1_meta.empty) begin
      first_w = '0;
      last_w  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
    if (s1_adv) begin
      front_value <= s1_meta.rev ? last_w : first_w;
      back_value  <= s1_meta.rev ? first_w : last_w;
      entry_count <= s1_meta.entry_count;
      is_empty    <= s1_meta.empty;
      status      <= s1_meta.status;
    end
  end

endmodule

// File: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of 64-bit words
// Ring buffer with push/pop at both ends and reversal by direction flag.
// ----------------------------------------------------------------------------
//
//   channel  handshake                    payload
//   -------  ---------------------------  ----------------------------------
//   item     item_valid / item_ready      op, value
//   result   result_valid / result_ready  front_value, back_value,
//                                         entry_count, is_empty, status
//
// One beat is taken per cycle while item_ready is high; its result is
// registered first by the storage RAM's read into the read stage, then in the result register.
// Reset clears the head slot, the word count, the direction flag and the
// valid bits; storage is not cleared, since only written slots ever reach the result.
// While a result waits, up to two beats are held inside; item_ready drops
// only when both the read stage and the result register are occupied.
//
// Every operation moves the head or the count by at most one slot, so the
// new front and back slots are known in the accept cycle and both are read
// from the two-port RAM at once. A word pushed in that same beat is not yet
// in the RAM output, so it is forwarded from the read stage's record.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [OP_W-1:0]      op,
  input  logic [WORD_W-1:0]    value,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [WORD_W-1:0]    front_value,
  output logic [WORD_W-1:0]    back_value,
  output logic [CNT_OUT_W-1:0] entry_count,
  output logic                 is_empty,
  output logic [1:0]           status
);

  localparam int AW = $clog2(DEPTH);

  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     rd_first_addr;
  logic [AW-1:0]     rd_last_addr;
  logic [WORD_W-1:0] rd_first;
  logic [WORD_W-1:0] rd_last;
  meta_t             meta;

  // A beat enters whenever the read stage is free or is moving on.
  assign accept = item_valid && item_ready;

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .value     (value),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .rd_first  (rd_first_addr),
    .rd_last   (rd_last_addr),
    .meta      (meta)
  );

  // The write is gated by accept so an idle or stalled cycle never stores.
  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we && accept),
    .waddr   (ram_waddr),
    .wdata   (value),
    .re      (accept),
    .raddr_a (rd_first_addr),
    .raddr_b (rd_last_addr),
    .rdata_a (rd_first),
    .rdata_b (rd_last)
  );

  deq_out u_out (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .meta         (meta),
    .rd_first     (rd_first),
    .rd_last      (rd_last),
    .take         (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .front_value  (front_value),
    .back_value   (back_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .status       (status)
  );

endmodule
